>>> sv/bleadp_pkg.sv
// ----------------------------------------------------------------------------
// bleadp_pkg - shared types and codes for the advertising data parser
// Item and record layouts, record kinds and small record builders.
// ----------------------------------------------------------------------------
`default_nettype none

package bleadp_pkg;

	localparam int MaxRecs = 3;

	localparam logic [3:0] K_FLAGS      = 4'd0;
	localparam logic [3:0] K_UUID16     = 4'd1;
	localparam logic [3:0] K_UUID128_LO = 4'd2;
	localparam logic [3:0] K_UUID128_HI = 4'd3;
	localparam logic [3:0] K_NAME       = 4'd4;
	localparam logic [3:0] K_TXPOWER    = 4'd5;
	localparam logic [3:0] K_SVC_UUID   = 4'd6;
	localparam logic [3:0] K_SVC_BYTE   = 4'd7;
	localparam logic [3:0] K_MFR        = 4'd8;
	localparam logic [3:0] K_DONE       = 4'd9;
	localparam logic [3:0] K_ERROR      = 4'd10;

	// AD structure types
	localparam logic [7:0] ET_FLAGS      = 8'h01;
	localparam logic [7:0] ET_UUID16_P   = 8'h02;
	localparam logic [7:0] ET_UUID16_C   = 8'h03;
	localparam logic [7:0] ET_UUID128_P  = 8'h06;
	localparam logic [7:0] ET_UUID128_C  = 8'h07;
	localparam logic [7:0] ET_NAME_SHORT = 8'h08;
	localparam logic [7:0] ET_NAME_FULL  = 8'h09;
	localparam logic [7:0] ET_TX_POWER   = 8'h0A;
	localparam logic [7:0] ET_SVC_DATA   = 8'h16;
	localparam logic [7:0] ET_MFR        = 8'hFF;

	typedef struct packed {
		logic signed [7:0] rssi_dbm;
		logic              address_public;
		logic [47:0]       bd_address;
		logic [4:0]        report_length;
		logic              first_of_report;
		logic [7:0]        data_byte;
	} item_t;

	typedef struct packed {
		logic [3:0]        record_kind;
		logic [63:0]       value;
		logic              element_end;
		logic              report_last;
		logic [47:0]       out_address;
		logic              out_public;
		logic signed [7:0] out_rssi;
	} rec_t;

	// records of one input word, filled from index 0 up
	typedef struct packed {
		rec_t [MaxRecs-1:0] recs;
		logic [1:0]         count;
	} batch_t;

	function automatic rec_t mk_rec(input logic [3:0] kind, input logic [63:0] value,
			input logic ee);
		rec_t r;
		r             = '0;
		r.record_kind = kind;
		r.value       = value;
		r.element_end = ee;
		return r;
	endfunction

	// done or error record closing the report
	function automatic rec_t mk_end(input logic [3:0] kind, input item_t it);
		rec_t r;
		r             = '0;
		r.record_kind = kind;
		r.report_last = 1'b1;
		if (kind == K_DONE) begin
			r.out_address = it.bd_address;
			r.out_public  = it.address_public;
			r.out_rssi    = it.rssi_dbm;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/bleadp_parse.sv
// ----------------------------------------------------------------------------
// bleadp_parse - structure parser state and record generation
// Holds the per-report parse state and works out the records of one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bleadp_parse
	import bleadp_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire item_t  item,
	input  wire logic   take,
	output batch_t      batch
);

	localparam logic [1:0] PH_LEN     = 2'd0;
	localparam logic [1:0] PH_TYPE    = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;

	localparam logic [4:0] UUID16_BYTES  = 5'd2;
	localparam logic [4:0] UUID128_BYTES = 5'd16;

	logic [1:0]   phase_q, c_phase, n_phase;
	logic [7:0]   left_q, c_left, n_left;
	logic [7:0]   etype_q, c_etype, n_etype;
	logic [4:0]   pos_q, c_pos, n_pos;
	logic [127:0] acc_q, c_acc, n_acc, lane_acc;
	logic [4:0]   acnt_q, c_acnt, n_acnt, lane_acnt;
	logic         ab_q, c_ab, n_ab;

	logic [1:0]   nrec;
	logic         end_now;
	logic [7:0]   d;
	logic [4:0]   len;

	assign d   = item.data_byte;
	assign len = item.report_length;

	always_comb begin
		// a first word starts from cleared state
		c_phase = item.first_of_report ? PH_LEN : phase_q;
		c_left  = item.first_of_report ? '0 : left_q;
		c_etype = item.first_of_report ? '0 : etype_q;
		c_pos   = item.first_of_report ? '0 : pos_q;
		c_acc   = item.first_of_report ? '0 : acc_q;
		c_acnt  = item.first_of_report ? '0 : acnt_q;
		c_ab    = item.first_of_report ? 1'b0 : ab_q;

		lane_acc = c_acc;
		for (int i = 0; i < 16; i++) begin
			if (c_acnt[3:0] == 4'(i))
				lane_acc[i*8 +: 8] = lane_acc[i*8 +: 8] | d;
		end
		lane_acnt = c_acnt + 5'd1;

		n_phase = c_phase;
		n_left  = c_left;
		n_etype = c_etype;
		n_pos   = c_pos;
		n_acc   = c_acc;
		n_acnt  = c_acnt;
		n_ab    = c_ab;
		nrec    = '0;
		end_now = 1'b0;
		batch   = '0;

		if (len == '0) begin
			if (item.first_of_report) begin
				batch.recs[nrec] = mk_end(K_DONE, item);
				nrec = nrec + 2'd1;
				n_ab = 1'b1;
			end
		end else if (!c_ab && c_pos < len) begin
			n_pos = c_pos + 5'd1;
			unique case (c_phase)
				PH_LEN: begin
					if (d == '0) begin
						batch.recs[nrec] = mk_end(K_DONE, item);
						nrec = nrec + 2'd1;
						n_ab = 1'b1;
						end_now = 1'b1;
					end else if ({4'b0, c_pos} + 9'd1 + {1'b0, d} > {4'b0, len}) begin
						batch.recs[nrec] = mk_end(K_ERROR, item);
						nrec = nrec + 2'd1;
						n_ab = 1'b1;
						end_now = 1'b1;
					end else begin
						n_left  = d;
						n_phase = PH_TYPE;
					end
				end
				PH_TYPE: begin
					n_etype = d;
					n_left  = c_left - 8'd1;
					n_acc   = '0;
					n_acnt  = '0;
					n_phase = (n_left != '0) ? PH_PAYLOAD : PH_LEN;
				end
				default: begin
					n_left = c_left - 8'd1;
					if (n_left == '0)
						n_phase = PH_LEN;
					unique case (c_etype) inside
						ET_FLAGS, ET_TX_POWER: begin
							// only the first payload byte counts
							if (c_acnt == '0) begin
								n_acnt = 5'd1;
								batch.recs[nrec] = mk_rec((c_etype == ET_FLAGS) ? K_FLAGS
									: K_TXPOWER, {56'b0, d}, 1'b1);
								nrec = nrec + 2'd1;
							end
						end
						ET_UUID16_P, ET_UUID16_C: begin
							n_acc  = lane_acc;
							n_acnt = lane_acnt;
							if (lane_acnt == UUID16_BYTES) begin
								batch.recs[nrec] = mk_rec(K_UUID16, lane_acc[63:0],
									n_left < 8'(UUID16_BYTES));
								nrec = nrec + 2'd1;
								n_acc  = '0;
								n_acnt = '0;
							end
						end
						ET_UUID128_P, ET_UUID128_C: begin
							n_acc  = lane_acc;
							n_acnt = lane_acnt;
							if (lane_acnt == UUID128_BYTES) begin
								batch.recs[nrec] = mk_rec(K_UUID128_LO, lane_acc[63:0], 1'b0);
								nrec = nrec + 2'd1;
								batch.recs[nrec] = mk_rec(K_UUID128_HI, lane_acc[127:64],
									n_left < 8'(UUID128_BYTES));
								nrec = nrec + 2'd1;
								n_acc  = '0;
								n_acnt = '0;
							end
						end
						ET_NAME_SHORT, ET_NAME_FULL: begin
							batch.recs[nrec] = mk_rec(K_NAME, {56'b0, d}, n_left == '0);
							nrec = nrec + 2'd1;
						end
						ET_SVC_DATA: begin
							if (c_acnt < UUID16_BYTES) begin
								n_acc  = lane_acc;
								n_acnt = lane_acnt;
								if (lane_acnt == UUID16_BYTES) begin
									batch.recs[nrec] = mk_rec(K_SVC_UUID, lane_acc[63:0],
										n_left == '0);
									nrec = nrec + 2'd1;
								end
							end else begin
								batch.recs[nrec] = mk_rec(K_SVC_BYTE, {56'b0, d}, n_left == '0);
								nrec = nrec + 2'd1;
							end
						end
						ET_MFR: begin
							batch.recs[nrec] = mk_rec(K_MFR, {56'b0, d}, n_left == '0);
							nrec = nrec + 2'd1;
						end
						default: begin
						end
					endcase
				end
			endcase
			if (!end_now && n_pos >= len) begin
				batch.recs[nrec] = mk_end(K_DONE, item);
				nrec = nrec + 2'd1;
				n_ab = 1'b1;
			end
		end
		batch.count = nrec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN;
			left_q  <= '0;
			etype_q <= '0;
			pos_q   <= '0;
			acc_q   <= '0;
			acnt_q  <= '0;
			ab_q    <= 1'b0;
		end else if (take) begin
			phase_q <= n_phase;
			left_q  <= n_left;
			etype_q <= n_etype;
			pos_q   <= n_pos;
			acc_q   <= n_acc;
			acnt_q  <= n_acnt;
			ab_q    <= n_ab;
		end
	end

	// once a report has ended nothing more comes out of it until the next first word
	a_quiet_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		ab_q && !item.first_of_report |-> batch.count == 2'd0)
		else $error("record produced after report end");

	// three records only when a 128-bit UUID completes on the closing byte
	a_three_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		batch.count == 2'd3 |-> batch.recs[2].record_kind == K_DONE
			&& batch.recs[0].record_kind == K_UUID128_LO)
		else $error("bad three-record word");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		take && batch.count != 2'd0 && batch.recs[0].report_last |=> ab_q)
		else $error("report end not recorded");

endmodule

`default_nettype wire

>>> sv/bleadp_outbuf.sv
// ----------------------------------------------------------------------------
// bleadp_outbuf - result register and record serialiser
// Holds the records of one word and hands them out one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bleadp_outbuf
	import bleadp_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire batch_t batch,
	input  wire logic   load,
	output logic        free,
	output logic        m_tvalid,
	input  wire logic   m_tready,
	output rec_t        rec
);

	rec_t [MaxRecs-1:0] rec_q;
	logic [1:0]         cnt_q;
	logic [1:0]         sel_q;
	logic               hs;
	logic               final_rec;

	assign m_tvalid  = cnt_q != '0;
	assign rec       = rec_q[sel_q];
	assign hs        = m_tvalid && m_tready;
	assign final_rec = (sel_q + 2'd1) == cnt_q;
	assign free      = (cnt_q == '0) || (hs && final_rec);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sel_q <= '0;
		end else if (load) begin
			cnt_q <= batch.count;
			sel_q <= '0;
		end else if (hs) begin
			if (final_rec) begin
				cnt_q <= '0;
				sel_q <= '0;
			end else begin
				sel_q <= sel_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			rec_q <= batch.recs;
	end

	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 |-> sel_q < cnt_q)
		else $error("record select out of range");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free && batch.count != '0)
		else $error("load into busy buffer");

	a_last_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && rec.report_last |-> final_rec)
		else $error("report end before last record of word");

endmodule

`default_nettype wire

>>> sv/ble_adv_data_parser_unit.sv
// ----------------------------------------------------------------------------
// ble_adv_data_parser_unit - advertising data structure parser
// Splits advertising report bytes into typed records.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)                                  tuser            tlast
//  s_*      in   data_byte[8] report_length[5] bd_address[48]        first_of_report  -
//                address_public[1] rssi_dbm[8] pad[2]
//  m_*      out  value[64] out_address[48] out_public[1]             record_kind[4]   report_last
//                out_rssi[8] pad[7]                                  element_end[1]
//
//  One word enters the input register per cycle while s_tready is high; the parser
//  turns it into zero to three records, held in the result register that drives m_*.
//  A word giving several records holds the serialiser until its last is taken, so
//  input words flow at one per cycle only while each yields at most one record.
//  m_tready low holds the records and, once the input register is full, s_tready.
//  arst_n clears parse state and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ble_adv_data_parser_unit
	import bleadp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [71:0]  s_tdata,   // data_byte, report_length, bd_address, address_public, rssi_dbm
	input  wire logic         s_tuser,   // first_of_report
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata,   // value, out_address, out_public, out_rssi
	output logic [4:0]        m_tuser,   // record_kind, element_end
	output logic              m_tlast    // report_last
);

	logic   valid_s1;
	item_t  item_s1;
	batch_t batch;
	logic   free;
	logic   adv;
	rec_t   rec;

	// words with no records never wait for the serialiser
	assign adv      = valid_s1 && (batch.count == '0 || free);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.data_byte       <= s_tdata[7:0];
			item_s1.report_length   <= s_tdata[12:8];
			item_s1.bd_address      <= s_tdata[60:13];
			item_s1.address_public  <= s_tdata[61];
			item_s1.rssi_dbm        <= s_tdata[69:62];
			item_s1.first_of_report <= s_tuser;
		end
	end

	bleadp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.take   (adv),
		.batch  (batch)
	);

	bleadp_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.batch    (batch),
		.load     (adv && batch.count != '0),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.rec      (rec)
	);

	assign m_tdata = {7'b0, rec.out_rssi, rec.out_public, rec.out_address, rec.value};
	assign m_tuser = {rec.element_end, rec.record_kind};
	assign m_tlast = rec.report_last;

endmodule

`default_nettype wire
